### src/ecgbr_pkg.sv
`default_nettype none

package ecgbr_pkg;

    localparam int DIV_W = 24;
    localparam int FRAME_LEN = 18;
    localparam int IDX_W = $clog2(FRAME_LEN);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    localparam logic [15:0] TIMER_PERIOD = 16'd20000;

    localparam logic [7:0] HDR_SYNC = 8'hAA;
    localparam logic [7:0] HDR_ID = 8'hF1;
    localparam logic [7:0] HDR_LEN = 8'h08;
    localparam logic [DIV_W-1:0] DIGIT_RECIP = 24'hCCCCCD;
    localparam int DIGIT_SHIFT = 27;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_TEMP = 2'd2;

    localparam logic [1:0] CFG_RISE_MARGIN = 2'd0;
    localparam logic [1:0] CFG_FALL_MARGIN = 2'd1;
    localparam logic [1:0] CFG_BEATS_PER_RATE = 2'd2;
    localparam logic [1:0] CFG_RATE_NUMERATOR = 2'd3;

    localparam logic [7:0] RISE_MARGIN_RST = 8'd15;
    localparam logic [7:0] FALL_MARGIN_RST = 8'd64;
    localparam logic [1:0] BEATS_PER_RATE_RST = 2'd3;
    localparam logic [23:0] RATE_NUMERATOR_RST = 24'd6000000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [23:0] ch1_raw;
        logic [23:0] ch2_raw;
        logic [15:0] temp_whole;
        logic [3:0]  temp_tenths;
    } in_word_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_RATE,
        ST_DIV_TEN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        logic     rate_write;
        logic     ten_write;
        logic     load_byte;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_is_sample;
        logic div_pend;
        logic div_done;
        logic out_free;
        logic byte_last;
    } dp_status_t;

endpackage

`default_nettype wire

### src/ecg_beat_rate_framer.sv
// Timer ticks, temperature updates and unused request words are taken without leaving idle.
// An ECG sample is accepted in idle, the detector result is checked in ST_CHECK,
// and ST_EMIT then loads one frame byte per cycle while the output is not stalled.
// A rate update adds a pass of the 24-bit divider, one quotient bit per cycle, in
// ST_DIV_RATE, and the decimal digits in ST_DIV_TEN.
// Reset is asynchronous and active low; it loads the register defaults and clears
// the detector, counters, rate, held temperature and the output valid flag.
`default_nettype none

module ecg_beat_rate_framer (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire ecgbr_pkg::in_word_t  in_word,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output ecgbr_pkg::out_word_t      out_word,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [23:0]          cfg_data
);

    ecgbr_pkg::ctrl_cmd_t  cmd;
    ecgbr_pkg::dp_status_t status;

    ecgbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ecgbr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

### src/ecgbr_div.sv
`default_nettype none

module ecgbr_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ecgbr_pkg::DIV_W-1:0] dividend,
    input  wire logic [ecgbr_pkg::DIV_W-1:0] divisor,
    output logic      [ecgbr_pkg::DIV_W-1:0] quotient,
    output logic                             done
);

    localparam int W = ecgbr_pkg::DIV_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     quot_reg;
    logic [W-1:0]     quot_next;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     divisor_reg;
    logic [W-1:0]     divisor_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [W:0]       shifted;
    logic             fits;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        shifted = {rem_reg, quot_reg[W-1]};
        fits = shifted >= {1'b0, divisor_reg};
        quot_next = quot_reg;
        rem_next = rem_reg;
        divisor_next = divisor_reg;
        count_next = count_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next = '0;
            divisor_next = divisor;
            count_next = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = W'(shifted - {1'b0, divisor_reg});
                quot_next = {quot_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b0};
            end
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign quotient = quot_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### src/ecgbr_dp.sv
`default_nettype none

module ecgbr_dp (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ecgbr_pkg::in_word_t    in_word,
    input  wire ecgbr_pkg::ctrl_cmd_t   cmd,
    output ecgbr_pkg::dp_status_t       status,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output ecgbr_pkg::out_word_t        out_word,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [23:0]            cfg_data
);

    localparam int W = ecgbr_pkg::DIV_W;
    localparam int IW = ecgbr_pkg::IDX_W;

    logic [7:0]  rise_margin_reg;
    logic [7:0]  fall_margin_reg;
    logic [1:0]  beats_per_rate_reg;
    logic [23:0] rate_numerator_reg;

    logic [7:0]  level_ref_reg;
    logic [7:0]  level_ref_next;
    logic        armed_off_reg;
    logic        armed_off_next;
    logic [1:0]  beat_count_reg;
    logic [1:0]  beat_count_next;
    logic [14:0] tick_count_reg;
    logic [14:0] tick_count_next;
    logic [23:0] beat_rate_reg;
    logic [15:0] temp_int_reg;
    logic [3:0]  temp_frac_reg;
    logic [7:0]  rate_tens_reg;
    logic [3:0]  rate_ones_reg;
    logic        div_pend_reg;
    logic        div_pend_next;

    logic [23:0] ch1_reg;
    logic [23:0] ch2_reg;
    logic [14:0] div_tick_reg;

    logic [IW-1:0] byte_idx_reg;
    logic [7:0]    sum_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    ecgbr_pkg::out_word_t out_word_reg;

    logic [7:0]  sample_byte;
    logic [7:0]  level_mid;
    logic [1:0]  beat_inc;
    logic [14:0] tick_inc;
    logic        rise;
    logic        fall;
    logic [7:0]  frame_byte;

    logic [W-1:0] div_dividend;
    logic [W-1:0] div_divisor;
    logic [W-1:0] div_quotient;
    logic         div_done;

    logic [2*W-1:0] ten_prod;
    logic [7:0]     ten_quot;
    logic [3:0]     ten_ones;

    assign div_dividend = rate_numerator_reg;
    assign div_divisor = W'(div_tick_reg);

    ecgbr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quotient),
        .done      (div_done)
    );

    // The tens value comes from a reciprocal multiply; kept in 8 bits, it is exact for rates below 2560.
    assign ten_prod = (2*W)'(beat_rate_reg) * (2*W)'(ecgbr_pkg::DIGIT_RECIP);
    assign ten_quot = ten_prod[ecgbr_pkg::DIGIT_SHIFT+7:ecgbr_pkg::DIGIT_SHIFT];
    assign ten_ones = beat_rate_reg[3:0] - {ten_quot[2:0], 1'b0} - {ten_quot[0], 3'd0};

    // The detector and the tick counter update in the cycle that takes the word.
    always_comb
    begin
        sample_byte = in_word.ch2_raw[15:8];
        rise = {1'b0, sample_byte} > ({1'b0, level_ref_reg} + {1'b0, rise_margin_reg});
        level_mid = rise ? sample_byte : level_ref_reg;
        beat_inc = beat_count_reg + 2'd1;
        fall = (level_mid < fall_margin_reg) || (sample_byte < (level_mid - fall_margin_reg));
        tick_inc = tick_count_reg + 15'd1;

        level_ref_next = level_ref_reg;
        armed_off_next = armed_off_reg;
        beat_count_next = beat_count_reg;
        tick_count_next = tick_count_reg;
        div_pend_next = div_pend_reg;

        if (cmd.accept)
        begin
            case (in_word.req_type)
                ecgbr_pkg::REQ_TICK:
                begin
                    if ({1'b0, tick_inc} >= ecgbr_pkg::TIMER_PERIOD)
                    begin
                        tick_count_next = '0;
                    end
                    else
                    begin
                        tick_count_next = tick_inc;
                    end
                end
                ecgbr_pkg::REQ_SAMPLE:
                begin
                    div_pend_next = 1'b0;
                    level_ref_next = level_mid;
                    if (rise && !armed_off_reg)
                    begin
                        armed_off_next = 1'b1;
                        beat_count_next = beat_inc;
                        if (beat_inc == beats_per_rate_reg)
                        begin
                            beat_count_next = '0;
                            tick_count_next = '0;
                            div_pend_next = tick_count_reg != '0;
                        end
                    end
                    if (fall)
                    begin
                        armed_off_next = 1'b0;
                        level_ref_next = sample_byte;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (byte_idx_reg)
            IW'(0):  frame_byte = ecgbr_pkg::HDR_SYNC;
            IW'(1):  frame_byte = ecgbr_pkg::HDR_SYNC;
            IW'(2):  frame_byte = ecgbr_pkg::HDR_ID;
            IW'(3):  frame_byte = ecgbr_pkg::HDR_LEN;
            IW'(4):  frame_byte = {8{ch1_reg[23]}};
            IW'(5):  frame_byte = ch1_reg[23:16];
            IW'(6):  frame_byte = ch1_reg[15:8];
            IW'(7):  frame_byte = ch1_reg[7:0];
            IW'(8):  frame_byte = {8{ch2_reg[23]}};
            IW'(9):  frame_byte = ch2_reg[23:16];
            IW'(10): frame_byte = ch2_reg[15:8];
            IW'(11): frame_byte = ch2_reg[7:0];
            IW'(12): frame_byte = rate_tens_reg;
            IW'(13): frame_byte = {4'd0, rate_ones_reg};
            IW'(14): frame_byte = temp_int_reg[15:8];
            IW'(15): frame_byte = temp_int_reg[7:0];
            IW'(16): frame_byte = {4'd0, temp_frac_reg};
            IW'(17): frame_byte = sum_reg;
            default: frame_byte = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_margin_reg <= ecgbr_pkg::RISE_MARGIN_RST;
            fall_margin_reg <= ecgbr_pkg::FALL_MARGIN_RST;
            beats_per_rate_reg <= ecgbr_pkg::BEATS_PER_RATE_RST;
            rate_numerator_reg <= ecgbr_pkg::RATE_NUMERATOR_RST;
            level_ref_reg <= '0;
            armed_off_reg <= 1'b0;
            beat_count_reg <= '0;
            tick_count_reg <= '0;
            beat_rate_reg <= '0;
            temp_int_reg <= '0;
            temp_frac_reg <= '0;
            rate_tens_reg <= '0;
            rate_ones_reg <= '0;
            div_pend_reg <= 1'b0;
            byte_idx_reg <= '0;
            sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ecgbr_pkg::CFG_RISE_MARGIN:    rise_margin_reg <= cfg_data[7:0];
                    ecgbr_pkg::CFG_FALL_MARGIN:    fall_margin_reg <= cfg_data[7:0];
                    ecgbr_pkg::CFG_BEATS_PER_RATE: beats_per_rate_reg <= cfg_data[1:0];
                    ecgbr_pkg::CFG_RATE_NUMERATOR: rate_numerator_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            level_ref_reg <= level_ref_next;
            armed_off_reg <= armed_off_next;
            beat_count_reg <= beat_count_next;
            tick_count_reg <= tick_count_next;
            div_pend_reg <= div_pend_next;
            if (cmd.accept && in_word.req_type == ecgbr_pkg::REQ_TEMP)
            begin
                temp_int_reg <= in_word.temp_whole;
                temp_frac_reg <= in_word.temp_tenths;
            end
            if (cmd.rate_write)
            begin
                beat_rate_reg <= div_quotient;
            end
            if (cmd.ten_write)
            begin
                rate_tens_reg <= ten_quot;
                rate_ones_reg <= ten_ones;
            end
            if (cmd.accept)
            begin
                byte_idx_reg <= '0;
                sum_reg <= '0;
            end
            else if (cmd.load_byte)
            begin
                byte_idx_reg <= byte_idx_reg + IW'(1);
                sum_reg <= sum_reg + frame_byte;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_word.req_type == ecgbr_pkg::REQ_SAMPLE)
        begin
            ch1_reg <= in_word.ch1_raw;
            ch2_reg <= in_word.ch2_raw;
            div_tick_reg <= tick_count_reg;
        end
        if (cmd.load_byte)
        begin
            out_word_reg.frame_byte <= frame_byte;
            out_word_reg.last_byte <= byte_idx_reg == ecgbr_pkg::LAST_IDX;
        end
    end

    assign status.in_is_sample = in_word.req_type == ecgbr_pkg::REQ_SAMPLE;
    assign status.div_pend = div_pend_reg;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.byte_last = byte_idx_reg == ecgbr_pkg::LAST_IDX;

    assign out_valid = out_valid_reg;
    assign out_word = out_word_reg;

endmodule

`default_nettype wire

### src/ecgbr_ctrl.sv
`default_nettype none

module ecgbr_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire ecgbr_pkg::dp_status_t status,
    output ecgbr_pkg::ctrl_cmd_t       cmd
);

    ecgbr_pkg::state_t state_reg;
    ecgbr_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ecgbr_pkg::ST_IDLE:
            begin
                if (in_valid && status.in_is_sample)
                begin
                    state_next = ecgbr_pkg::ST_CHECK;
                end
            end
            ecgbr_pkg::ST_CHECK:
            begin
                state_next = status.div_pend ? ecgbr_pkg::ST_DIV_RATE : ecgbr_pkg::ST_EMIT;
            end
            ecgbr_pkg::ST_DIV_RATE:
            begin
                if (status.div_done)
                begin
                    state_next = ecgbr_pkg::ST_DIV_TEN;
                end
            end
            ecgbr_pkg::ST_DIV_TEN:
            begin
                state_next = ecgbr_pkg::ST_EMIT;
            end
            ecgbr_pkg::ST_EMIT:
            begin
                if (status.out_free && status.byte_last)
                begin
                    state_next = ecgbr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ecgbr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmd.accept = 1'b0;
        cmd.div_start = 1'b0;
        cmd.rate_write = 1'b0;
        cmd.ten_write = 1'b0;
        cmd.load_byte = 1'b0;
        case (state_reg)
            ecgbr_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.accept = in_valid;
            end
            ecgbr_pkg::ST_CHECK:
            begin
                cmd.div_start = status.div_pend;
            end
            ecgbr_pkg::ST_DIV_RATE:
            begin
                cmd.rate_write = status.div_done;
            end
            ecgbr_pkg::ST_DIV_TEN:
            begin
                cmd.ten_write = 1'b1;
            end
            ecgbr_pkg::ST_EMIT:
            begin
                cmd.load_byte = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecgbr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/ecgbr_checker.sv
`default_nettype none

module ecgbr_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire ecgbr_pkg::in_word_t  in_word,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire ecgbr_pkg::out_word_t out_word,
    input wire logic                 cfg_we
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // A sample is not followed at once by another input word.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_word.req_type == ecgbr_pkg::REQ_SAMPLE |=> in_stall)
        else $error("input taken right after a sample");

    // The word shown after a frame's checksum, if any, starts a new header.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_word.last_byte
        |=> !out_valid || (out_word.frame_byte == ecgbr_pkg::HDR_SYNC && !out_word.last_byte))
        else $error("frame does not restart with the sync byte");

    // Configuration is never written while a frame is still in flight.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !in_stall && !out_valid)
        else $error("configuration written while a word is in flight");

endmodule

bind ecg_beat_rate_framer ecgbr_checker u_ecgbr_checker (.*);

`default_nettype wire

### test/tb_top.sv
module tb_top;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_WORDS = 60;

    typedef struct packed {
        ecgbr_pkg::in_word_t w;
        logic       pinned;
        logic [7:0] rate_tens;
        logic [7:0] rate_units;
    } plan_row_t;

    typedef struct packed {
        logic [7:0]  rise;
        logic [7:0]  fall;
        logic [1:0]  beats;
        logic [23:0] numer;
    } detector_setup_t;

    localparam plan_row_t DIRECTED_PLAN [22] = '{
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'h000000, 24'h000000, 16'h0000, 4'h0}, 1'b1, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'h7FFFFF, 24'h800000, 16'h0000, 4'h0}, 1'b1, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'h800000, 24'hFFFFFF, 16'h0000, 4'h0}, 1'b1, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_TICK, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 4'hF}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_TICK, 24'h000000, 24'h000000, 16'h0000, 4'h0}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_TICK, 24'h5A5A5A, 24'hA5A5A5, 16'h1234, 4'h7}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_TEMP, 24'h000000, 24'h000000, 16'hFFFF, 4'h9}, 1'b0, 8'd0, 8'd0},
        '{'{REQ_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 4'hF}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'h000000, 24'h000000, 16'h0000, 4'h0}, 1'b1, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'h123456, 24'h00FF00, 16'h0000, 4'h0}, 1'b1, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'h000000, 24'h000000, 16'h0000, 4'h0}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'h7FFFFF, 24'h00FF00, 16'h0000, 4'h0}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_TEMP, 24'hFFFFFF, 24'hFFFFFF, 16'h0000, 4'hF}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'h000000, 24'h001000, 16'h0000, 4'h0}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'h000000, 24'h002000, 16'h0000, 4'h0}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'h000001, 24'h00FF00, 16'h0000, 4'h0}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'h000000, 24'h000000, 16'h0000, 4'h0}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'hFFFFFE, 24'h00FF00, 16'h0000, 4'h0}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'hFFFFFF, 24'hFFFFFF, 16'h0000, 4'h0}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_TICK, 24'h000000, 24'h000000, 16'h0000, 4'h0}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_SAMPLE, 24'h800000, 24'h7FFFFF, 16'h0000, 4'h0}, 1'b0, 8'd0, 8'd0},
        '{'{ecgbr_pkg::REQ_TEMP, 24'h000000, 24'h000000, 16'h8000, 4'h0}, 1'b0, 8'd0, 8'd0}
    };

    localparam detector_setup_t DETECTOR_SETUPS [5] = '{
        '{8'd15, 8'd64, 2'd3, 24'd6000000},
        '{8'd0, 8'd0, 2'd1, 24'd1},
        '{8'd255, 8'd255, 2'd0, 24'hFFFFFF},
        '{8'd8, 8'd32, 2'd2, 24'd123456},
        '{8'd40, 8'd128, 2'd1, 24'd750000}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    ecgbr_pkg::in_word_t  in_word = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    ecgbr_pkg::out_word_t out_word;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = ecgbr_pkg::CFG_RISE_MARGIN;
    logic [23:0]          cfg_data = '0;

    logic [7:0]  rise_m;
    logic [7:0]  fall_m;
    logic [1:0]  beats_target;
    logic [23:0] rate_numer;
    logic [7:0]  level_mark;
    logic        disarmed;
    logic [1:0]  beats_seen;
    logic [14:0] ticks;
    logic [23:0] rate_now;
    logic [15:0] temp_whole_held;
    logic [3:0]  temp_tenths_held;

    ecgbr_pkg::out_word_t frame_bytes_due [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          out_hold = 0;
    bit          out_took = 1'b0;
    bit          calm_in = 1'b0;
    bit          calm_out = 1'b0;
    bit          swing_hi = 1'b1;

    ecg_beat_rate_framer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    function automatic void predict_word(input ecgbr_pkg::in_word_t w, input logic pinned,
                                         input logic [7:0] tens, input logic [7:0] units);
        logic [7:0]  f [ecgbr_pkg::FRAME_LEN];
        logic [31:0] c1;
        logic [31:0] c2;
        logic [7:0]  b;
        logic [7:0]  sum;
        case (w.req_type)
            ecgbr_pkg::REQ_TICK:
            begin
                ticks = ticks + 15'd1;
                if ({1'b0, ticks} >= ecgbr_pkg::TIMER_PERIOD)
                    ticks = '0;
            end
            ecgbr_pkg::REQ_TEMP:
            begin
                temp_whole_held = w.temp_whole;
                temp_tenths_held = w.temp_tenths;
            end
            ecgbr_pkg::REQ_SAMPLE:
            begin
                c1 = {{8{w.ch1_raw[23]}}, w.ch1_raw};
                c2 = {{8{w.ch2_raw[23]}}, w.ch2_raw};
                b = c2[15:8];
                if ({1'b0, b} > {1'b0, level_mark} + {1'b0, rise_m})
                begin
                    level_mark = b;
                    if (!disarmed)
                    begin
                        beats_seen = beats_seen + 2'd1;
                        disarmed = 1'b1;
                        if (beats_seen == beats_target)
                        begin
                            if (ticks != '0)
                                rate_now = rate_numer / {9'd0, ticks};
                            beats_seen = '0;
                            ticks = '0;
                        end
                    end
                end
                if (level_mark < fall_m || b < level_mark - fall_m)
                begin
                    disarmed = 1'b0;
                    level_mark = b;
                end
                f[0] = ecgbr_pkg::HDR_SYNC;
                f[1] = ecgbr_pkg::HDR_SYNC;
                f[2] = ecgbr_pkg::HDR_ID;
                f[3] = ecgbr_pkg::HDR_LEN;
                for (int i = 0; i < 4; i++)
                begin
                    f[4 + i] = c1[31 - 8 * i -: 8];
                    f[8 + i] = c2[31 - 8 * i -: 8];
                end
                f[12] = pinned ? tens : 8'(rate_now / 24'd10);
                f[13] = pinned ? units : 8'(rate_now % 24'd10);
                f[14] = temp_whole_held[15:8];
                f[15] = temp_whole_held[7:0];
                f[16] = {4'd0, temp_tenths_held};
                sum = '0;
                for (int i = 0; i < ecgbr_pkg::FRAME_LEN - 1; i++)
                    sum = sum + f[i];
                f[ecgbr_pkg::FRAME_LEN - 1] = sum;
                for (int i = 0; i < ecgbr_pkg::FRAME_LEN; i++)
                    frame_bytes_due.push_back('{frame_byte: f[i],
                                                last_byte: (i == ecgbr_pkg::FRAME_LEN - 1)});
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_word(input ecgbr_pkg::in_word_t w, input int gap, input logic pinned,
                             input logic [7:0] tens, input logic [7:0] units);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_word(w, pinned, tens, units);
        @(negedge clk);
    endtask

    task automatic drain_frames(input int extra);
        in_valid <= 1'b0;
        @(negedge clk);
        while (frame_bytes_due.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            ecgbr_pkg::CFG_RISE_MARGIN:    rise_m = val[7:0];
            ecgbr_pkg::CFG_FALL_MARGIN:    fall_m = val[7:0];
            ecgbr_pkg::CFG_BEATS_PER_RATE: beats_target = val[1:0];
            ecgbr_pkg::CFG_RATE_NUMERATOR: rate_numer = val;
            default:
            begin
            end
        endcase
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : watch_out
        ecgbr_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            out_took = 1'b1;
            if (frame_bytes_due.size() == 0)
                flag_mismatch($sformatf("frame byte %02h with no frame pending",
                                        out_word.frame_byte));
            else
            begin
                want = frame_bytes_due.pop_front();
                if (out_word.frame_byte !== want.frame_byte)
                    flag_mismatch($sformatf("frame_byte got %02h want %02h",
                                            out_word.frame_byte, want.frame_byte));
                if (out_word.last_byte !== want.last_byte)
                    flag_mismatch($sformatf("last_byte got %b want %b",
                                            out_word.last_byte, want.last_byte));
            end
        end
    end

    always @(negedge clk)
    begin
        if (out_took)
        begin
            out_took = 1'b0;
            out_hold = calm_out ? 0 : $urandom_range(0, 9);
        end
        if (out_hold > 0)
        begin
            out_hold--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("** ecg_beat_rate_framer: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        ecgbr_pkg::in_word_t w;
        int                  pick;
        rise_m = ecgbr_pkg::RISE_MARGIN_RST;
        fall_m = ecgbr_pkg::FALL_MARGIN_RST;
        beats_target = ecgbr_pkg::BEATS_PER_RATE_RST;
        rate_numer = ecgbr_pkg::RATE_NUMERATOR_RST;
        level_mark = '0;
        disarmed = 1'b0;
        beats_seen = '0;
        ticks = '0;
        rate_now = '0;
        temp_whole_held = '0;
        temp_tenths_held = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_PLAN[i])
            send_word(DIRECTED_PLAN[i].w, $urandom_range(0, 9), DIRECTED_PLAN[i].pinned,
                      DIRECTED_PLAN[i].rate_tens, DIRECTED_PLAN[i].rate_units);

        for (int p = 0; p < $size(DETECTOR_SETUPS); p++)
        begin
            drain_frames(SETTLE_CYCLES);
            write_reg(ecgbr_pkg::CFG_RISE_MARGIN, 24'(DETECTOR_SETUPS[p].rise));
            write_reg(ecgbr_pkg::CFG_FALL_MARGIN, 24'(DETECTOR_SETUPS[p].fall));
            write_reg(ecgbr_pkg::CFG_BEATS_PER_RATE, 24'(DETECTOR_SETUPS[p].beats));
            write_reg(ecgbr_pkg::CFG_RATE_NUMERATOR, DETECTOR_SETUPS[p].numer);
            cfg_we <= 1'b0;

            for (int n = 0; n < RANDOM_WORDS; n++)
            begin
                if (n % 16 == 0)
                begin
                    calm_in = ($urandom_range(0, 3) == 0);
                    calm_out = ($urandom_range(0, 3) == 0);
                end
                if (n == RANDOM_WORDS / 2 || $urandom_range(0, 39) == 0)
                    drain_frames(0);
                pick = $urandom_range(0, 99);
                w.ch1_raw = 24'($urandom);
                w.ch2_raw = 24'($urandom);
                w.temp_whole = 16'($urandom);
                w.temp_tenths = 4'($urandom);
                if (pick < 45)
                    w.req_type = ecgbr_pkg::REQ_TICK;
                else if (pick < 90)
                begin
                    w.req_type = ecgbr_pkg::REQ_SAMPLE;
                    if ($urandom_range(0, 9) < 7)
                    begin
                        w.ch2_raw[15:8] = swing_hi ? 8'($urandom_range(200, 255))
                                                   : 8'($urandom_range(0, 40));
                        swing_hi = !swing_hi;
                    end
                end
                else if (pick < 96)
                begin
                    w.req_type = ecgbr_pkg::REQ_TEMP;
                    if ($urandom_range(0, 7) != 0)
                        w.temp_tenths = 4'($urandom_range(0, 9));
                end
                else
                    w.req_type = REQ_UNUSED;
                send_word(w, calm_in ? 0 : $urandom_range(0, 9), 1'b0, '0, '0);
            end
        end

        in_valid <= 1'b0;
        calm_out = 1'b0;
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && frame_bytes_due.size() == 0)
            $display("** ecg_beat_rate_framer: PASSED **");
        else
            $display("** ecg_beat_rate_framer: FAILED **");
        $finish;
    end

endmodule
